// ===== sv/b14e_pkg.sv =====
package b14e_pkg;

    localparam logic [15:0] UNIT_BASE   = 16'h4E00;
    localparam logic [15:0] MARK_BASE   = 16'h3D00;
    localparam int          GROUP_BITS  = 14;
    localparam logic [2:0]  LAST_MOD    = 3'd6;   // bytes_mod_seven value before wrap
    localparam int          QUEUE_DEPTH_DEF = 4;

    // one code unit with its end-of-message flag
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } t_unit;

    // all units caused by one input byte, slot 0 leaves first
    typedef struct packed {
        t_unit [2:0] units;
        logic  [1:0] count;
    } t_job;

endpackage

// ===== sv/b14e_if.sv =====
interface b14e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b14e_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ===== sv/bytes_to_14bit_unit_encoder.sv =====
// A byte accepted by the front goes into the job queue, then its first unit into the
//   output register of the back end. Throughput: one byte per cycle in unless the
//   queue is full; 7 bytes give 4 units, a final byte adds up to 2 more. The single
//   unit register of the back end limits output to one unit a cycle while the sink is
//   ready; the job queue absorbs the bursts at message ends.
// Reset: synchronous, active low; clears bit state, byte count, queue and output valid.
module bytes_to_14bit_unit_encoder #(
    parameter int QUEUE_DEPTH = b14e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b14e_byte_if.sink    i_byte,
    b14e_unit_if.source  o_unit
);
    import b14e_pkg::*;

    // front -> queue
    logic  q_push;
    t_job  q_job;
    logic  q_full;
    // queue -> back
    logic  q_pop;
    logic  q_empty;
    t_job  q_head;

    // Front: packs bits, cuts 14-bit groups, builds the unit list for each byte
    // (group, padded tail, remainder marker) and pushes non-empty lists.
    b14e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_job)
    );

    // Job queue lets the byte side keep moving while the unit side stalls.
    b14e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: walks the head job one unit a cycle into the output register while it is empty or taken.
    b14e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_unit  (o_unit)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    // every pushed job holds one to three units
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_job.count == 2'd1 || q_job.count == 2'd2 || q_job.count == 2'd3))
        else $error("job with bad unit count");

    // output is idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_unit.valid)
        else $error("output valid after reset");

endmodule

// ===== sv/b14e_front.sv =====
module b14e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b14e_byte_if.sink       i_byte,
    input  logic            i_full,
    output logic            o_push,
    output b14e_pkg::t_job  o_job
);
    import b14e_pkg::*;

    logic [13:0] r_acc;
    logic [3:0]  r_held;
    logic [2:0]  r_mod;
    logic [13:0] n_acc;
    logic [3:0]  n_held;
    logic [2:0]  n_mod;

    logic        accept;
    logic [21:0] tmp;
    logic [4:0]  total;
    logic        full_grp;
    logic [3:0]  held;
    logic [13:0] grp;
    logic [13:0] rest;
    logic [13:0] pad_grp;
    logic [2:0]  rem;
    t_job        job;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;

    always_comb begin
        tmp      = {r_acc, i_byte.data_byte};
        total    = {1'b0, r_held} + 5'd8;
        full_grp = (total >= 5'(GROUP_BITS));
        grp      = '0;
        if (full_grp) begin
            held = 4'(total - 5'(GROUP_BITS));
            grp  = 14'(tmp >> held);
            rest = tmp[13:0] & ((14'd1 << held) - 14'd1);
        end else begin
            held = total[3:0];
            rest = tmp[13:0];
        end
        pad_grp = rest << (4'(GROUP_BITS) - held);
        rem     = (r_mod == LAST_MOD) ? 3'd0 : r_mod + 3'd1;
    end

    // unit list for this byte
    always_comb begin
        logic [1:0] k;
        k   = 2'd0;
        job = '0;
        if (full_grp) begin
            job.units[k] = '{code_unit: UNIT_BASE + {2'b00, grp}, last_unit: 1'b0};
            k = k + 2'd1;
        end
        if (i_byte.last_byte) begin
            if (rem == 3'd0) begin
                if (full_grp) begin
                    job.units[0].last_unit = 1'b1;
                end else begin
                    // cannot follow a consistent state; close with the held bits
                    job.units[k] = '{code_unit: UNIT_BASE + {2'b00, pad_grp}, last_unit: 1'b1};
                    k = k + 2'd1;
                end
            end else begin
                if (held != 4'd0) begin
                    job.units[k] = '{code_unit: UNIT_BASE + {2'b00, pad_grp},
                                     last_unit: 1'b0};
                    k = k + 2'd1;
                end
                job.units[k] = '{code_unit: MARK_BASE + {13'd0, rem}, last_unit: 1'b1};
                k = k + 2'd1;
            end
        end
        job.count = k;
    end

    assign o_job  = job;
    assign o_push = accept && (job.count != 2'd0);

    always_comb begin
        n_acc  = r_acc;
        n_held = r_held;
        n_mod  = r_mod;
        if (accept) begin
            if (i_byte.last_byte) begin
                n_acc  = '0;
                n_held = '0;
                n_mod  = '0;
            end else begin
                n_acc  = rest;
                n_held = held;
                n_mod  = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
            r_mod  <= '0;
        end else begin
            r_acc  <= n_acc;
            r_held <= n_held;
            r_mod  <= n_mod;
        end
    end

endmodule

// ===== sv/b14e_queue.sv =====
module b14e_queue #(
    parameter int DEPTH = b14e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b14e_pkg::t_job  i_job,
    input  logic            i_pop,
    output b14e_pkg::t_job  o_head,
    output logic            o_full,
    output logic            o_empty
);
    import b14e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== sv/b14e_back.sv =====
module b14e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  b14e_pkg::t_job  i_head,
    output logic            o_pop,
    b14e_unit_if.source     o_unit
);
    import b14e_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_unit      r_unit;
    logic [1:0] n_idx;
    logic       n_valid;
    logic       load;
    logic       at_end;

    assign load   = !i_empty && (!r_valid || o_unit.ready);
    assign at_end = (r_idx == i_head.count - 2'd1);
    assign o_pop  = load && at_end;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = at_end ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
        end else if (o_unit.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit <= i_head.units[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_unit.valid     = r_valid;
    assign o_unit.code_unit = r_unit.code_unit;
    assign o_unit.last_unit = r_unit.last_unit;

endmodule
